>>> sv/pcc_pkg.sv
`default_nettype none
package pcc_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned ERR_W   = DATA_W + 1;
  localparam int unsigned DERR_W  = DATA_W + 2;
  localparam int unsigned PROD_W  = DATA_W + ERR_W;
  localparam int unsigned DPROD_W = DATA_W + DERR_W;
  // p + d + integrator + rounding bias, with headroom
  localparam int unsigned SUM_W   = DPROD_W + 3;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned APB_AW      = 5;
  localparam int unsigned APB_DW      = 32;

  localparam logic signed [DATA_W-1:0] OUT_MAX = 16'sd32767;
  localparam logic signed [DATA_W-1:0] OUT_MIN = -16'sd32768;

  typedef enum logic [2:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_INTEG_MIN  = 3'd3,
    REG_INTEG_MAX  = 3'd4,
    REG_DRIVE_MIN  = 3'd5,
    REG_DRIVE_MAX  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] integ_gain;
    logic signed [DATA_W-1:0] deriv_gain;
    logic signed [DATA_W-1:0] integ_min;
    logic signed [DATA_W-1:0] integ_max;
    logic signed [DATA_W-1:0] drive_min;
    logic signed [DATA_W-1:0] drive_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    prop_gain:  '0,
    integ_gain: '0,
    deriv_gain: '0,
    integ_min:  OUT_MIN,
    integ_max:  OUT_MAX,
    drive_min:  OUT_MIN,
    drive_max:  OUT_MAX
  };

  // load enables of the two output-side stages
  typedef struct packed {
    logic sum_en;
    logic out_en;
  } out_en_t;

endpackage
`default_nettype wire

>>> sv/pcc_mult.sv
`default_nettype none
module pcc_mult
  import pcc_pkg::*;
(
  input  wire                        clk_i,
  input  wire                        en_i,
  input  wire cfg_t                  cfg_i,
  input  wire logic signed [ERR_W-1:0]  err_i,
  input  wire logic signed [DERR_W-1:0] derr_i,
  output logic signed [PROD_W-1:0]   p_o,
  output logic signed [PROD_W-1:0]   i_o,
  output logic signed [DPROD_W-1:0]  d_o,
  output logic signed [ERR_W-1:0]    err_o
);

  logic signed [PROD_W-1:0]  p_d, i_d;
  logic signed [DPROD_W-1:0] d_d;

  // three independent gain products, all exact
  assign p_d = PROD_W'(cfg_i.prop_gain) * PROD_W'(err_i);
  assign i_d = PROD_W'(cfg_i.integ_gain) * PROD_W'(err_i);
  assign d_d = DPROD_W'(cfg_i.deriv_gain) * DPROD_W'(derr_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o   <= p_d;
      i_o   <= i_d;
      d_o   <= d_d;
      err_o <= err_i;
    end
  end

endmodule
`default_nettype wire

>>> sv/pcc_integ.sv
`default_nettype none
module pcc_integ
  import pcc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  wire cfg_t                    cfg_i,
  input  wire logic signed [PROD_W-1:0]  p_i,
  input  wire logic signed [PROD_W-1:0]  i_i,
  input  wire logic signed [DPROD_W-1:0] d_i,
  input  wire logic signed [ERR_W-1:0]   err_i,
  output logic signed [SUM_W-1:0]      pd_o,
  output logic signed [DATA_W+FRAC_BITS:0] integ_o,
  output logic signed [ERR_W-1:0]      err_o
);

  localparam int unsigned INTEG_W = DATA_W + FRAC_BITS + 1;
  localparam int unsigned ISUM_W  = ((INTEG_W > PROD_W) ? INTEG_W : PROD_W) + 1;

  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [ISUM_W-1:0]  acc, lim_hi, lim_lo;
  logic signed [SUM_W-1:0]   pd_d;

  assign lim_hi = ISUM_W'(cfg_i.integ_max) <<< FRAC_BITS;
  assign lim_lo = ISUM_W'(cfg_i.integ_min) <<< FRAC_BITS;
  assign acc    = ISUM_W'(integ_q) + ISUM_W'(i_i);
  assign pd_d   = SUM_W'(p_i) + SUM_W'(d_i);

  // upper limit wins when the limits are inverted
  always_comb begin
    if (acc > lim_hi) begin
      integ_d = INTEG_W'(lim_hi);
    end else if (acc < lim_lo) begin
      integ_d = INTEG_W'(lim_lo);
    end else begin
      integ_d = INTEG_W'(acc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (en_i) begin
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pd_o  <= pd_d;
      err_o <= err_i;
    end
  end

  assign integ_o = integ_q;

`ifndef SYNTHESIS
  a_integ_in_limits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (cfg_i.integ_min <= cfg_i.integ_max) |=>
      (ISUM_W'(integ_q) <= $past(lim_hi)) && (ISUM_W'(integ_q) >= $past(lim_lo)))
    else $error("integrator left its limits");
`endif

endmodule
`default_nettype wire

>>> sv/pcc_out.sv
`default_nettype none
module pcc_out
  import pcc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire out_en_t                     en_i,
  input  wire cfg_t                        cfg_i,
  input  wire logic signed [SUM_W-1:0]         pd_i,
  input  wire logic signed [DATA_W+FRAC_BITS:0] integ_i,
  input  wire logic signed [ERR_W-1:0]         err_i,
  output logic signed [DATA_W-1:0]         drive_o,
  output logic signed [DATA_W-1:0]         unclamped_o,
  output logic signed [ERR_W-1:0]          err_o
);

  localparam logic [SUM_W-1:0] BIAS = SUM_W'((64'd1 << FRAC_BITS) - 64'd1);

  logic signed [SUM_W-1:0]  sum, biased, whole;
  logic signed [DATA_W-1:0] unc_d, unc_q, drive_d;
  logic signed [ERR_W-1:0]  err_q;

  // truncate toward zero: bias negative sums before the arithmetic shift
  assign sum    = pd_i + SUM_W'(integ_i);
  assign biased = sum[SUM_W-1] ? (sum + $signed(BIAS)) : sum;
  assign whole  = biased >>> FRAC_BITS;

  always_comb begin
    if (whole > SUM_W'(OUT_MAX)) begin
      unc_d = OUT_MAX;
    end else if (whole < SUM_W'(OUT_MIN)) begin
      unc_d = OUT_MIN;
    end else begin
      unc_d = DATA_W'(whole);
    end
  end

  always_comb begin
    if (unc_q > cfg_i.drive_max) begin
      drive_d = cfg_i.drive_max;
    end else if (unc_q < cfg_i.drive_min) begin
      drive_d = cfg_i.drive_min;
    end else begin
      drive_d = unc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum_en) begin
      unc_q <= unc_d;
      err_q <= err_i;
    end
    if (en_i.out_en) begin
      drive_o     <= drive_d;
      unclamped_o <= unc_q;
      err_o       <= err_q;
    end
  end

`ifndef SYNTHESIS
  a_trunc_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i.sum_en |=> (unc_q == '0) || (unc_q[DATA_W-1] == $past(sum[SUM_W-1])))
    else $error("truncated output has wrong sign");

  a_drive_clamp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i.out_en && (cfg_i.drive_min <= cfg_i.drive_max) |=>
      (drive_o <= $past(cfg_i.drive_max)) && (drive_o >= $past(cfg_i.drive_min)))
    else $error("drive outside its clamp");
`endif

endmodule
`default_nettype wire

>>> sv/pid_controller_clamped.sv
// Clamped positional PID controller. Each stream transfer on the slave side is one
// control step (setpoint, feedback); each produces exactly one transfer on the master
// side with the clamped drive, the saturated unclamped drive and the loop error.
// The block is a five-stage pipeline (error, gain products, integrator update,
// sum/truncate/saturate, drive clamp): it takes one step per clock while the master
// side does not stall, and each result passes through these stages in order before it
// is presented on the master side. The integrator update closes its loop within a
// single stage, so steps may arrive back to back. Gains are signed with FRAC_BITS
// fraction bits; integrator limits are in output units. Registers are to be written
// over APB only while no step is in flight; the block itself does not enforce this.
`default_nettype none
module pid_controller_clamped
  import pcc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // slave stream
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire [IN_TDATA_W-1:0]   s_axis_tdata,   // setpoint[15:0], feedback[31:16]
  // master stream
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // drive[15:0], drive_unclamped[31:16],
                                                 // loop_error[48:32], zero[55:49]
  // APB config
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire [APB_AW-1:0]       paddr,
  input  wire [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int unsigned INTEG_W = DATA_W + FRAC_BITS + 1;

  cfg_t cfg_q, cfg_d;
  logic cfg_we;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic adv1, adv2, adv3, adv4, adv5;
  logic en1, en2, en3;
  out_en_t out_en;

  logic signed [DATA_W-1:0]  sp, fb;
  logic signed [ERR_W-1:0]   err_d, err1_q, prev_err_q, err2, err3;
  logic signed [DERR_W-1:0]  derr_d, derr1_q;
  logic signed [PROD_W-1:0]  p2, i2;
  logic signed [DPROD_W-1:0] d2;
  logic signed [SUM_W-1:0]   pd3;
  logic signed [INTEG_W-1:0] integ3;
  logic signed [DATA_W-1:0]  drive, unclamped;
  logic signed [ERR_W-1:0]   err5;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    case (paddr[4:2])
      REG_PROP_GAIN:  cfg_d.prop_gain  = pwdata[DATA_W-1:0];
      REG_INTEG_GAIN: cfg_d.integ_gain = pwdata[DATA_W-1:0];
      REG_DERIV_GAIN: cfg_d.deriv_gain = pwdata[DATA_W-1:0];
      REG_INTEG_MIN:  cfg_d.integ_min  = pwdata[DATA_W-1:0];
      REG_INTEG_MAX:  cfg_d.integ_max  = pwdata[DATA_W-1:0];
      REG_DRIVE_MIN:  cfg_d.drive_min  = pwdata[DATA_W-1:0];
      REG_DRIVE_MAX:  cfg_d.drive_max  = pwdata[DATA_W-1:0];
      default:        cfg_d = cfg_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_PROP_GAIN:  prdata = {{(APB_DW-DATA_W){1'b0}}, cfg_q.prop_gain};
      REG_INTEG_GAIN: prdata = {{(APB_DW-DATA_W){1'b0}}, cfg_q.integ_gain};
      REG_DERIV_GAIN: prdata = {{(APB_DW-DATA_W){1'b0}}, cfg_q.deriv_gain};
      REG_INTEG_MIN:  prdata = {{(APB_DW-DATA_W){1'b0}}, cfg_q.integ_min};
      REG_INTEG_MAX:  prdata = {{(APB_DW-DATA_W){1'b0}}, cfg_q.integ_max};
      REG_DRIVE_MIN:  prdata = {{(APB_DW-DATA_W){1'b0}}, cfg_q.drive_min};
      REG_DRIVE_MAX:  prdata = {{(APB_DW-DATA_W){1'b0}}, cfg_q.drive_max};
      default:        prdata = '0;
    endcase
  end

  // ---------------- pipeline flow control ----------------
  // a stage takes new data when it is empty or its content moves on
  assign adv5 = !v5_q || m_axis_tready;
  assign adv4 = !v4_q || adv5;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign s_axis_tready  = adv1;
  assign en1            = s_axis_tvalid && adv1;
  assign en2            = v1_q && adv2;
  assign en3            = v2_q && adv3;
  assign out_en.sum_en  = v3_q && adv4;
  assign out_en.out_en  = v4_q && adv5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
      if (adv5) v5_q <= v4_q;
    end
  end

  // ---------------- stage 1: error and error difference ----------------
  assign sp     = s_axis_tdata[DATA_W-1:0];
  assign fb     = s_axis_tdata[2*DATA_W-1:DATA_W];
  assign err_d  = ERR_W'(sp) - ERR_W'(fb);
  assign derr_d = DERR_W'(err_d) - DERR_W'(prev_err_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
    end else if (en1) begin
      prev_err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      err1_q  <= err_d;
      derr1_q <= derr_d;
    end
  end

  pcc_mult u_mult (
    .clk_i  (clk_i),
    .en_i   (en2),
    .cfg_i  (cfg_q),
    .err_i  (err1_q),
    .derr_i (derr1_q),
    .p_o    (p2),
    .i_o    (i2),
    .d_o    (d2),
    .err_o  (err2)
  );

  pcc_integ #(
    .FRAC_BITS (FRAC_BITS)
  ) u_integ (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en3),
    .cfg_i   (cfg_q),
    .p_i     (p2),
    .i_i     (i2),
    .d_i     (d2),
    .err_i   (err2),
    .pd_o    (pd3),
    .integ_o (integ3),
    .err_o   (err3)
  );

  pcc_out #(
    .FRAC_BITS (FRAC_BITS)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (out_en),
    .cfg_i       (cfg_q),
    .pd_i        (pd3),
    .integ_i     (integ3),
    .err_i       (err3),
    .drive_o     (drive),
    .unclamped_o (unclamped),
    .err_o       (err5)
  );

  assign m_axis_tvalid = v5_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - 2*DATA_W - ERR_W){1'b0}}, err5, unclamped, drive};

`ifndef SYNTHESIS
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> s_axis_tready)
    else $error("input stage empty but not ready");

  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("accepted transfer lost at input stage");
`endif

endmodule
`default_nettype wire
